// ===== rtl/core/swmm_pkg.sv =====
package swmm_pkg;

	localparam int WINDOW_MAX = 64;
	localparam int DATA_W = 32;
	localparam int LEN_W = 7;
	localparam int AGE_W = $clog2(WINDOW_MAX + 1);

	typedef logic signed [DATA_W-1:0] sample_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef logic [AGE_W-1:0] age_t;

	// one candidate of a monotonic list
	typedef struct packed {
		logic valid;
		sample_t value;
		age_t age;
	} entry_t;

	typedef struct packed {
		entry_t min_e;
		entry_t max_e;
	} pair_t;

	// what a cell shows its neighbours: aged entries and whether they survive the new word
	typedef struct packed {
		logic keep_min;
		logic keep_max;
		pair_t aged;
	} link_t;

endpackage

// ===== rtl/core/swmm_if.sv =====
interface swmm_sample_if;
	logic valid;
	logic ready;
	swmm_pkg::sample_t sample;
	logic restart;

	modport source (output valid, output sample, output restart, input ready);
	modport sink (input valid, input sample, input restart, output ready);
endinterface

interface swmm_result_if;
	logic valid;
	logic ready;
	swmm_pkg::sample_t window_min;
	swmm_pkg::sample_t window_max;

	modport source (output valid, output window_min, output window_max, input ready);
	modport sink (input valid, input window_min, input window_max, output ready);
endinterface

// ===== rtl/core/swmm_cell.sv =====
module swmm_cell (
	input logic clk,
	input logic arst_n,
	input logic clear,
	input logic advance,
	input logic restart,
	input logic is_head,
	input swmm_pkg::sample_t sample,
	input logic drop_min,
	input logic drop_max,
	input logic prev_keep_min,
	input logic prev_keep_max,
	input swmm_pkg::link_t next_link,
	output swmm_pkg::link_t link,
	output swmm_pkg::pair_t upd
);

	swmm_pkg::pair_t cur_q;
	swmm_pkg::entry_t aged_min;
	swmm_pkg::entry_t aged_max;

	function automatic swmm_pkg::entry_t age_entry(input swmm_pkg::entry_t e);
		swmm_pkg::entry_t r;
		r = e;
		if (e.age < swmm_pkg::AGE_W'(swmm_pkg::WINDOW_MAX)) begin
			r.age = e.age + swmm_pkg::AGE_W'(1);
		end
		return r;
	endfunction

	// keep the surviving source, or take the new word just behind the last survivor
	function automatic swmm_pkg::entry_t pick(input swmm_pkg::entry_t src_e, input logic src_keep,
			input logic prev_keep, input swmm_pkg::sample_t s);
		swmm_pkg::entry_t r;
		r = '0;
		if (src_keep) begin
			r = src_e;
		end else if (prev_keep) begin
			r.valid = 1'b1;
			r.value = s;
			r.age = '0;
		end
		return r;
	endfunction

	always_comb begin
		aged_min = age_entry(cur_q.min_e);
		aged_max = age_entry(cur_q.max_e);
		link.aged.min_e = aged_min;
		link.aged.max_e = aged_max;
		link.keep_min = aged_min.valid && (aged_min.value < sample) && !restart;
		link.keep_max = aged_max.valid && (aged_max.value > sample) && !restart;
	end

	// a drop at the front shifts the whole list one cell towards the head
	// the head takes the new word when nothing behind it survives
	always_comb begin
		if (drop_min) begin
			upd.min_e = pick(next_link.aged.min_e, next_link.keep_min,
				link.keep_min || is_head, sample);
		end else begin
			upd.min_e = pick(aged_min, link.keep_min, prev_keep_min, sample);
		end
		if (drop_max) begin
			upd.max_e = pick(next_link.aged.max_e, next_link.keep_max,
				link.keep_max || is_head, sample);
		end else begin
			upd.max_e = pick(aged_max, link.keep_max, prev_keep_max, sample);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (clear) begin
			cur_q.min_e.valid <= 1'b0;
			cur_q.max_e.valid <= 1'b0;
		end else if (advance) begin
			cur_q <= upd;
		end
	end

endmodule

// ===== rtl/core/sliding_window_min_max.sv =====
// sliding window minimum and maximum over a chain of WINDOW_MAX candidate cells
// one word per cycle while the output is free; its result is registered the cycle after
// the rate is set by the cell chain, which updates both candidate lists together on each word
// a result waits in the output register and a new word is still taken if it is being read
// reset and any window length write empty both lists and the warm-up count; length resets to 1
module sliding_window_min_max (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input swmm_pkg::len_t cfg_data,
	swmm_sample_if.sink samples,
	swmm_result_if.source results
);

	swmm_pkg::len_t window_length_q;
	swmm_pkg::len_t eff_len;
	logic [swmm_pkg::AGE_W-1:0] seen_q;
	logic [swmm_pkg::AGE_W-1:0] seen_next;
	logic out_valid_q;
	swmm_pkg::sample_t out_min_q;
	swmm_pkg::sample_t out_max_q;
	logic advance;
	logic drop_min;
	logic drop_max;
	logic res_valid;
	swmm_pkg::link_t links [swmm_pkg::WINDOW_MAX];
	swmm_pkg::pair_t cell_upd [swmm_pkg::WINDOW_MAX];

	always_comb begin
		if (window_length_q == '0) begin
			eff_len = swmm_pkg::LEN_W'(1);
		end else if (window_length_q > swmm_pkg::LEN_W'(swmm_pkg::WINDOW_MAX)) begin
			eff_len = swmm_pkg::LEN_W'(swmm_pkg::WINDOW_MAX);
		end else begin
			eff_len = window_length_q;
		end
	end

	assign samples.ready = !out_valid_q || results.ready;
	assign advance = samples.valid && samples.ready;

	// only the head can go stale, ages along the list are distinct
	assign drop_min = links[0].aged.min_e.valid && !samples.restart
		&& (swmm_pkg::LEN_W'(links[0].aged.min_e.age) >= eff_len);
	assign drop_max = links[0].aged.max_e.valid && !samples.restart
		&& (swmm_pkg::LEN_W'(links[0].aged.max_e.age) >= eff_len);

	for (genvar i = 0; i < swmm_pkg::WINDOW_MAX; i++) begin : g_cell
		if (i == 0) begin : g_head
			swmm_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.clear(cfg_we),
				.advance(advance),
				.restart(samples.restart),
				.is_head(1'b1),
				.sample(samples.sample),
				.drop_min(drop_min),
				.drop_max(drop_max),
				.prev_keep_min(1'b1),
				.prev_keep_max(1'b1),
				.next_link((swmm_pkg::WINDOW_MAX > 1) ? links[(i+1) % swmm_pkg::WINDOW_MAX]
					: swmm_pkg::link_t'('0)),
				.link(links[i]),
				.upd(cell_upd[i])
			);
		end else if (i == swmm_pkg::WINDOW_MAX - 1) begin : g_tail
			swmm_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.clear(cfg_we),
				.advance(advance),
				.restart(samples.restart),
				.is_head(1'b0),
				.sample(samples.sample),
				.drop_min(drop_min),
				.drop_max(drop_max),
				.prev_keep_min(links[i-1].keep_min),
				.prev_keep_max(links[i-1].keep_max),
				.next_link(swmm_pkg::link_t'('0)),
				.link(links[i]),
				.upd(cell_upd[i])
			);
		end else begin : g_mid
			swmm_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.clear(cfg_we),
				.advance(advance),
				.restart(samples.restart),
				.is_head(1'b0),
				.sample(samples.sample),
				.drop_min(drop_min),
				.drop_max(drop_max),
				.prev_keep_min(links[i-1].keep_min),
				.prev_keep_max(links[i-1].keep_max),
				.next_link(links[i+1]),
				.link(links[i]),
				.upd(cell_upd[i])
			);
		end
	end

	always_comb begin
		if (samples.restart) begin
			seen_next = swmm_pkg::AGE_W'(1);
		end else if (seen_q < swmm_pkg::AGE_W'(swmm_pkg::WINDOW_MAX)) begin
			seen_next = seen_q + swmm_pkg::AGE_W'(1);
		end else begin
			seen_next = seen_q;
		end
		res_valid = swmm_pkg::LEN_W'(seen_next) >= eff_len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= swmm_pkg::LEN_W'(1);
			seen_q <= '0;
		end else if (cfg_we) begin
			window_length_q <= cfg_data;
			seen_q <= '0;
		end else if (advance) begin
			seen_q <= seen_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_min_q <= cell_upd[0].min_e.value;
			out_max_q <= cell_upd[0].max_e.value;
		end
	end

	assign results.valid = out_valid_q;
	assign results.window_min = out_min_q;
	assign results.window_max = out_max_q;

`ifndef ASSERT_OFF
	a_head_filled: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !cfg_we |=> links[0].aged.min_e.valid && links[0].aged.max_e.valid)
		else $error("head cell empty after a word");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_min_q <= out_max_q)
		else $error("window minimum above maximum");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> seen_q == '0 && !links[0].aged.min_e.valid && !links[0].aged.max_e.valid)
		else $error("length write did not clear the window");

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= swmm_pkg::AGE_W'(swmm_pkg::WINDOW_MAX))
		else $error("warm-up count overran");
`endif

endmodule
